@@ hw/rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants, types and the sine table for the stereo chorus delay.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    localparam int LINE_DEPTH   = 1024;
    localparam int SINE_ENTRIES = 1024;
    localparam int SAMPLE_BITS  = 24;

    localparam int LINE_BITS = $clog2(LINE_DEPTH);
    localparam int SINE_BITS = $clog2(SINE_ENTRIES);
    localparam int FRAC_BITS = 8;
    localparam int POS_BITS  = LINE_BITS + FRAC_BITS;
    localparam int FILL_W    = LINE_BITS + 1;

    localparam int SINE_W  = 16;
    localparam int PHASE_W = 32;
    localparam int BASE_W  = 18;
    localparam int DEPTH_W = 16;
    localparam int STEP_W  = 24;
    localparam int MIX_W   = 16;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam int MIX_SHIFT  = 15;
    localparam int MIX_UNITY  = 1 << MIX_SHIFT;
    localparam int ROUND_HALF = 1 << (MIX_SHIFT - 1);

    localparam int MUL_A_W = SAMPLE_BITS + 2;
    localparam int MUL_B_W = MIX_SHIFT + 2;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = MUL_P_W + 1;

    localparam int DSUM_W    = ((BASE_W > POS_BITS) ? BASE_W : POS_BITS) + 3;
    localparam int MAX_DELAY = (LINE_DEPTH - 2) * 256;
    localparam int TOTAL_POS = LINE_DEPTH * 256;

    localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(36864);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(9216);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(134218);
    localparam logic [MIX_W-1:0]   MIX_RESET   = MIX_W'(9830);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_DELAY = 3'd0,
        REG_MOD_DEPTH  = 3'd1,
        REG_PHASE_STEP = 3'd2,
        REG_WET_MIX    = 3'd3
    } cfg_reg_t;

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

    // quarter-wave polynomial, q1.15 result
    function automatic logic signed [SINE_W-1:0] sine_of_phase(input logic [PHASE_W-1:0] p);
        logic [1:0]  quad;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        quad = p[31:30];
        x    = 64'(p[29:14]);
        if (quad[0])
        begin
            x = 64'd65536 - x;
        end
        x2 = (x * x) >> 16;
        t  = (64'd4765 * x2) >> 16;
        t  = 64'd42155 - t;
        t  = (t * x2) >> 16;
        t  = 64'd102939 - t;
        s  = ((t * x) >> 16) >> 1;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        sine_of_phase = quad[1] ? -SINE_W'(s) : SINE_W'(s);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            tab[k] = sine_of_phase(PHASE_W'((64'(k) << PHASE_W) / SINE_ENTRIES));
        end
        build_sine_tab = tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

@@ hw/rtl/scd_if.sv @@
// ----------------------------------------------------------------------------
// scd_if
// Valid/ready channels for stereo frames in and chorus frames out.
// ----------------------------------------------------------------------------
`default_nettype none

interface scd_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [scd_pkg::SAMPLE_BITS-1:0]   left_in;
    logic signed [scd_pkg::SAMPLE_BITS-1:0]   right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scd_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [scd_pkg::SAMPLE_BITS-1:0]   left_out;
    logic signed [scd_pkg::SAMPLE_BITS-1:0]   right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/scd_ram.sv @@
// ----------------------------------------------------------------------------
// scd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/scd_mul.sv @@
// ----------------------------------------------------------------------------
// scd_mul
// Shared signed multiplier with a registered product, held when not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_mul (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic signed [scd_pkg::MUL_A_W-1:0]   a,
    input  wire logic signed [scd_pkg::MUL_B_W-1:0]   b,
    output logic signed      [scd_pkg::MUL_P_W-1:0]   p
);

    logic signed [scd_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ hw/rtl/stereo_chorus_delay_top.sv @@
// ----------------------------------------------------------------------------
// stereo_chorus_delay_top
// Stereo chorus: modulated delay lines with linear interpolation and wet mix.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      left_in, right_in   (s24 q1.23)
//  out_ch    out   valid / ready      left_out, right_out (s24 q1.23)
//  cfg       in    cfg_we             cfg_index, cfg_data
//
//  each item runs through the accept cycle and ten sequencer steps that
//  share one multiplier and one read port of the delay line ram
//  a finished item sits in the output register; the next item is taken
//  while it waits, and the last step stalls only if it is still not taken
//  no clearing pass after reset: a fill count masks unwritten line entries
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    scd_in_if.sink                                    in_ch,
    scd_out_if.source                                 out_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [scd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int S  = scd_pkg::SAMPLE_BITS;
    localparam int LB = scd_pkg::LINE_BITS;
    localparam int PB = scd_pkg::POS_BITS;
    localparam int FB = scd_pkg::FRAC_BITS;
    localparam int AW = scd_pkg::MUL_A_W;
    localparam int BW = scd_pkg::MUL_B_W;
    localparam int PW = scd_pkg::MUL_P_W;
    localparam int DW = scd_pkg::DSUM_W;
    localparam int FW = scd_pkg::FILL_W;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MOD   = 11'b000_0000_0010,
        ST_DELAY = 11'b000_0000_0100,
        ST_ADDR  = 11'b000_0000_1000,
        ST_RD0   = 11'b000_0001_0000,
        ST_RD1   = 11'b000_0010_0000,
        ST_INTL  = 11'b000_0100_0000,
        ST_INTR  = 11'b000_1000_0000,
        ST_MIXL  = 11'b001_0000_0000,
        ST_MIXR  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    function automatic logic signed [S-1:0] mix_sat(
        input logic signed [S-1:0]  dry,
        input logic signed [PW-1:0] prod
    );
        logic signed [scd_pkg::ACC_W-1:0] acc;
        logic signed [scd_pkg::ACC_W-1:0] q;
        acc = (scd_pkg::ACC_W'(dry) <<< scd_pkg::MIX_SHIFT) + scd_pkg::ACC_W'(prod)
            + scd_pkg::ACC_W'(scd_pkg::ROUND_HALF);
        q = acc >>> scd_pkg::MIX_SHIFT;
        if ((&q[scd_pkg::ACC_W-1:S-1]) || !(|q[scd_pkg::ACC_W-1:S-1]))
        begin
            mix_sat = q[S-1:0];
        end
        else if (q[scd_pkg::ACC_W-1])
        begin
            mix_sat = {1'b1, {(S-1){1'b0}}};
        end
        else
        begin
            mix_sat = {1'b0, {(S-1){1'b1}}};
        end
    endfunction

    state_t state_reg, state_next;

    logic [scd_pkg::BASE_W-1:0]  base_reg;
    logic [scd_pkg::DEPTH_W-1:0] depth_reg;
    logic [scd_pkg::STEP_W-1:0]  step_reg;
    logic [scd_pkg::MIX_W-1:0]   mix_reg;

    logic [LB-1:0]                  wi_reg;
    logic [scd_pkg::PHASE_W-1:0]    phase_reg;
    logic [FW-1:0]                  fill_reg;
    logic                           out_valid_reg;

    logic signed [scd_pkg::SINE_W-1:0] sine_reg;
    logic signed [S-1:0]  dry_l_reg, dry_r_reg;
    logic [PB-1:0]        delay_reg;
    logic [LB-1:0]        idx_reg, nxt_reg;
    logic [FB-1:0]        frac_reg;
    logic                 v0_reg, v1_reg;
    logic signed [S-1:0]  a_l_reg, a_r_reg, b_r_reg;
    logic signed [S-1:0]  wet_l_reg, wet_r_reg;
    logic signed [S-1:0]  mix_l_reg;
    logic signed [S-1:0]  left_out_reg, right_out_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 load_out;
    logic [63:0]          sidx_wide;
    logic [scd_pkg::SINE_BITS-1:0] sidx;

    logic                 ram_we;
    logic [LB-1:0]        raddr;
    logic [2*S-1:0]       rdata;
    logic signed [S-1:0]  rd_l, rd_r;

    logic                 mul_en;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [DW-1:0] dsum;
    logic [PB-1:0]        delay_next;
    logic signed [PB+1:0] pos_diff;
    logic [PB-1:0]        rp;
    logic [LB-1:0]        rp_idx;
    logic [scd_pkg::MIX_W-1:0] w_eff;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = left_out_reg;
    assign out_ch.right_out = right_out_reg;

    assign sidx_wide = (64'(phase_reg) * 64'(scd_pkg::SINE_ENTRIES)) >> scd_pkg::PHASE_W;
    assign sidx      = scd_pkg::SINE_BITS'(sidx_wide);

    assign w_eff = (mix_reg > scd_pkg::MIX_W'(scd_pkg::MIX_UNITY))
                 ? scd_pkg::MIX_W'(scd_pkg::MIX_UNITY) : mix_reg;

    // delay line ram, left in the upper half
    assign ram_we = in_acc;
    assign raddr  = (state_reg == ST_RD0) ? idx_reg : nxt_reg;

    scd_ram #(
        .WIDTH (2 * S),
        .DEPTH (scd_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata ({in_ch.left_in, in_ch.right_in}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_l = rdata[2*S-1:S];
    assign rd_r = rdata[S-1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_MOD:
            begin
                mul_a = AW'(sine_reg);
                mul_b = $signed(BW'(depth_reg));
            end
            ST_INTL:
            begin
                mul_a = (v1_reg ? AW'(rd_l) : AW'(0)) - AW'(a_l_reg);
                mul_b = $signed(BW'(frac_reg));
            end
            ST_INTR:
            begin
                mul_a = AW'(b_r_reg) - AW'(a_r_reg);
                mul_b = $signed(BW'(frac_reg));
            end
            ST_MIXL:
            begin
                mul_a = AW'(wet_l_reg) - AW'(dry_l_reg);
                mul_b = $signed(BW'(w_eff));
            end
            ST_MIXR:
            begin
                mul_a = AW'(wet_r_reg) - AW'(dry_r_reg);
                mul_b = $signed(BW'(w_eff));
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    scd_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // delay from lfo, clamped to the line
    always_comb
    begin
        dsum = $signed(DW'(base_reg)) + DW'(mul_p >>> scd_pkg::MIX_SHIFT);
        if (dsum[DW-1])
        begin
            delay_next = '0;
        end
        else if (dsum > DW'(scd_pkg::MAX_DELAY))
        begin
            delay_next = PB'(scd_pkg::MAX_DELAY);
        end
        else
        begin
            delay_next = PB'(dsum);
        end
    end

    // read position with wraparound
    always_comb
    begin
        pos_diff = $signed((PB + 2)'({wi_reg, {FB{1'b0}}})) - $signed((PB + 2)'(delay_reg));
        if (pos_diff[PB+1])
        begin
            rp = PB'(pos_diff + (PB + 2)'(scd_pkg::TOTAL_POS));
        end
        else
        begin
            rp = PB'(pos_diff);
        end
        rp_idx = rp[PB-1:FB];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_MOD;
            ST_MOD:   state_next = ST_DELAY;
            ST_DELAY: state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_INTL;
            ST_INTL:  state_next = ST_INTR;
            ST_INTR:  state_next = ST_MIXL;
            ST_MIXL:  state_next = ST_MIXR;
            ST_MIXR:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= scd_pkg::BASE_RESET;
            depth_reg     <= scd_pkg::DEPTH_RESET;
            step_reg      <= scd_pkg::STEP_RESET;
            mix_reg       <= scd_pkg::MIX_RESET;
            wi_reg        <= '0;
            phase_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    scd_pkg::REG_BASE_DELAY: base_reg  <= cfg_data[scd_pkg::BASE_W-1:0];
                    scd_pkg::REG_MOD_DEPTH:  depth_reg <= cfg_data[scd_pkg::DEPTH_W-1:0];
                    scd_pkg::REG_PHASE_STEP: step_reg  <= cfg_data[scd_pkg::STEP_W-1:0];
                    scd_pkg::REG_WET_MIX:    mix_reg   <= cfg_data[scd_pkg::MIX_W-1:0];
                    default:                 ;
                endcase
            end
            if (in_acc && (fill_reg != FW'(scd_pkg::LINE_DEPTH)))
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                wi_reg        <= (wi_reg == LB'(scd_pkg::LINE_DEPTH - 1))
                               ? '0 : wi_reg + LB'(1);
                phase_reg     <= phase_reg + scd_pkg::PHASE_W'(step_reg);
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dry_l_reg <= in_ch.left_in;
            dry_r_reg <= in_ch.right_in;
            sine_reg  <= scd_pkg::SINE_TAB[sidx];
        end
        if (state_reg == ST_DELAY)
        begin
            delay_reg <= delay_next;
        end
        if (state_reg == ST_ADDR)
        begin
            idx_reg  <= rp_idx;
            nxt_reg  <= (rp_idx == LB'(scd_pkg::LINE_DEPTH - 1)) ? '0 : rp_idx + LB'(1);
            frac_reg <= rp[FB-1:0];
        end
        // entries not yet written since reset read as zero
        if (state_reg == ST_RD0)
        begin
            v0_reg <= (fill_reg == FW'(scd_pkg::LINE_DEPTH)) || (FW'(idx_reg) < fill_reg);
            v1_reg <= (fill_reg == FW'(scd_pkg::LINE_DEPTH)) || (FW'(nxt_reg) < fill_reg);
        end
        if (state_reg == ST_RD1)
        begin
            a_l_reg <= v0_reg ? rd_l : '0;
            a_r_reg <= v0_reg ? rd_r : '0;
        end
        if (state_reg == ST_INTL)
        begin
            b_r_reg <= v1_reg ? rd_r : '0;
        end
        if (state_reg == ST_INTR)
        begin
            wet_l_reg <= a_l_reg + S'(mul_p >>> FB);
        end
        if (state_reg == ST_MIXL)
        begin
            wet_r_reg <= a_r_reg + S'(mul_p >>> FB);
        end
        if (state_reg == ST_MIXR)
        begin
            mix_l_reg <= mix_sat(dry_l_reg, mul_p);
        end
        if (load_out)
        begin
            left_out_reg  <= mix_l_reg;
            right_out_reg <= mix_sat(dry_r_reg, mul_p);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks for the stereo chorus delay, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [scd_pkg::SAMPLE_BITS-1:0]  left_out,
    input wire logic [scd_pkg::SAMPLE_BITS-1:0]  right_out
);

    // block stays busy after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input ready too soon after an item");

    // a new result appears only as the sequencer returns to idle
    a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
        else $error("result appeared outside the final step");

    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
        else $error("output item changed while stalled");

endmodule

bind stereo_chorus_delay_top scd_checker u_scd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out)
);

`default_nettype wire
